// File: rtl/adx_pkg.sv
// ----------------------------------------------------------------------------
// ADX ADPCM decoder package
// Shared constants, controller states and control/status bundles.
// ----------------------------------------------------------------------------
package adx_pkg;

	localparam int NUM_CHANNELS = 2;
	localparam int CHAN_W       = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam int BYTE_W       = 8;
	localparam int NIB_W        = 4;
	localparam int SCALE_W      = 16;
	localparam int HIST_W       = 32;
	localparam int PCM_W        = 16;
	localparam int FRAME_LEN    = 18;
	localparam int POS_W        = $clog2(FRAME_LEN + 1);

	localparam int GAIN         = 32'h4000;
	localparam int SCALE_SHIFT  = 2;
	localparam int GAIN_SHIFT   = $clog2(GAIN) + SCALE_SHIFT;
	localparam int COEF_W       = 16;
	localparam int COEF1        = 32'h7298;
	localparam int COEF2        = 32'h3350;
	localparam int PRED_SHIFT   = 14;

	localparam int GAIN_W       = NIB_W + SCALE_W + 1;
	localparam int PROD_W       = COEF_W + HIST_W;
	localparam int SUM_W        = 40;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FETCH,
		ST_MUL,
		ST_SUM
	} state_t;

	typedef struct packed {
		logic load;
		logic fetch;
		logic mul;
		logic sum;
		logic nib;
	} cmd_t;

	typedef struct packed {
		logic is_data;
		logic out_free;
	} status_t;

endpackage

// File: rtl/adx_ctrl.sv
// ----------------------------------------------------------------------------
// ADX decoder controller
// Sequences byte capture, frame bookkeeping and the two prediction steps.
// ----------------------------------------------------------------------------
module adx_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  adx_pkg::status_t status,
	output adx_pkg::cmd_t    cmd
);

	adx_pkg::state_t state_q;
	adx_pkg::state_t state_d;
	logic            nib_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			adx_pkg::ST_IDLE: begin
				if (s_tvalid) begin
					state_d = adx_pkg::ST_FETCH;
				end
			end
			adx_pkg::ST_FETCH: begin
				state_d = status.is_data ? adx_pkg::ST_MUL : adx_pkg::ST_IDLE;
			end
			adx_pkg::ST_MUL: begin
				state_d = adx_pkg::ST_SUM;
			end
			adx_pkg::ST_SUM: begin
				if (status.out_free) begin
					state_d = nib_q ? adx_pkg::ST_IDLE : adx_pkg::ST_MUL;
				end
			end
			default: begin
				state_d = adx_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		s_tready  = 1'b0;
		cmd       = '0;
		cmd.nib   = nib_q;
		unique case (state_q)
			adx_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				cmd.load = s_tvalid;
			end
			adx_pkg::ST_FETCH: begin
				cmd.fetch = 1'b1;
			end
			adx_pkg::ST_MUL: begin
				cmd.mul = 1'b1;
			end
			adx_pkg::ST_SUM: begin
				cmd.sum = status.out_free;
			end
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= adx_pkg::ST_IDLE;
			nib_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.fetch) begin
				nib_q <= 1'b0;
			end else if (cmd.sum) begin
				nib_q <= 1'b1;
			end
		end
	end

endmodule

// File: rtl/adx_datapath.sv
// ----------------------------------------------------------------------------
// ADX decoder datapath
// Per-channel frame state, predictor multipliers, clamp and output register.
// ----------------------------------------------------------------------------
module adx_datapath (
	input  logic                       clk,
	input  logic                       arst_n,
	input  adx_pkg::cmd_t              cmd,
	output adx_pkg::status_t           status,
	input  logic [adx_pkg::BYTE_W-1:0] in_byte,
	input  logic [adx_pkg::CHAN_W-1:0] in_chan,
	input  logic                       in_restart,
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [adx_pkg::PCM_W-1:0]  m_tdata,
	output logic [adx_pkg::CHAN_W-1:0] m_tuser,
	output logic                       m_tlast
);

	logic [adx_pkg::BYTE_W-1:0]         byte_q;
	logic [adx_pkg::CHAN_W-1:0]         chan_q;
	logic                               restart_q;

	logic [adx_pkg::POS_W-1:0]          frame_pos_q [adx_pkg::NUM_CHANNELS];
	logic [adx_pkg::SCALE_W-1:0]        scale_q     [adx_pkg::NUM_CHANNELS];
	logic signed [adx_pkg::HIST_W-1:0]  h1_q        [adx_pkg::NUM_CHANNELS];
	logic signed [adx_pkg::HIST_W-1:0]  h2_q        [adx_pkg::NUM_CHANNELS];

	logic signed [adx_pkg::GAIN_W-1:0]  gain_s1;
	logic signed [adx_pkg::PROD_W-1:0]  p1_s1;
	logic signed [adx_pkg::PROD_W-1:0]  p2_s1;

	logic                               out_valid_q;
	logic [adx_pkg::PCM_W-1:0]          out_data_q;
	logic [adx_pkg::CHAN_W-1:0]         out_chan_q;
	logic                               out_last_q;

	logic                               chan_ok;
	logic [adx_pkg::POS_W-1:0]          pos_raw;
	logic [adx_pkg::POS_W-1:0]          pos;
	logic [adx_pkg::POS_W-1:0]          pos_next;
	logic [adx_pkg::NIB_W-1:0]          nib;
	logic signed [adx_pkg::NIB_W-1:0]   code;
	logic signed [adx_pkg::SCALE_W:0]   scale_ext;
	logic signed [adx_pkg::COEF_W:0]    coef1;
	logic signed [adx_pkg::COEF_W:0]    coef2;
	logic signed [adx_pkg::SUM_W-1:0]   gain_term;
	logic signed [adx_pkg::SUM_W-1:0]   t1;
	logic signed [adx_pkg::SUM_W-1:0]   t2;
	logic signed [adx_pkg::SUM_W-1:0]   sum;
	logic                               sat_hi;
	logic                               sat_lo;
	logic signed [adx_pkg::HIST_W-1:0]  sample;

	assign chan_ok  = (int'(chan_q) < adx_pkg::NUM_CHANNELS);
	assign pos_raw  = restart_q ? '0 : frame_pos_q[chan_q];
	assign pos      = (pos_raw >= adx_pkg::POS_W'(adx_pkg::FRAME_LEN)) ? '0 : pos_raw;
	assign pos_next = (pos == adx_pkg::POS_W'(adx_pkg::FRAME_LEN - 1)) ? '0 :
		pos + adx_pkg::POS_W'(1);

	assign status.is_data  = chan_ok && (pos >= adx_pkg::POS_W'(2));
	assign status.out_free = !out_valid_q || m_tready;

	assign nib       = cmd.nib ? byte_q[adx_pkg::NIB_W-1:0] :
		byte_q[adx_pkg::BYTE_W-1:adx_pkg::NIB_W];
	assign code      = signed'(nib);
	assign scale_ext = signed'({1'b0, scale_q[chan_q]});
	assign coef1     = signed'({1'b0, adx_pkg::COEF_W'(adx_pkg::COEF1)});
	assign coef2     = signed'({1'b0, adx_pkg::COEF_W'(adx_pkg::COEF2)});

	assign gain_term = adx_pkg::SUM_W'(gain_s1) <<< adx_pkg::GAIN_SHIFT;
	assign t1        = adx_pkg::SUM_W'(p1_s1 >>> adx_pkg::PRED_SHIFT);
	assign t2        = adx_pkg::SUM_W'(p2_s1 >>> adx_pkg::PRED_SHIFT);
	assign sum       = gain_term + t1 - t2;
	assign sat_hi    = !sum[adx_pkg::SUM_W-1] && (|sum[adx_pkg::SUM_W-2:adx_pkg::HIST_W-1]);
	assign sat_lo    = sum[adx_pkg::SUM_W-1] && !(&sum[adx_pkg::SUM_W-2:adx_pkg::HIST_W-1]);

	always_comb begin
		if (sat_hi) begin
			sample = {1'b0, {(adx_pkg::HIST_W-1){1'b1}}};
		end else if (sat_lo) begin
			sample = {1'b1, {(adx_pkg::HIST_W-1){1'b0}}};
		end else begin
			sample = sum[adx_pkg::HIST_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			byte_q    <= in_byte;
			chan_q    <= in_chan;
			restart_q <= in_restart;
		end
		if (cmd.mul) begin
			gain_s1 <= adx_pkg::GAIN_W'(code * scale_ext);
			p1_s1   <= adx_pkg::PROD_W'(coef1 * h1_q[chan_q]);
			p2_s1   <= adx_pkg::PROD_W'(coef2 * h2_q[chan_q]);
		end
		if (cmd.sum) begin
			out_data_q <= sample[adx_pkg::HIST_W-1:adx_pkg::HIST_W-adx_pkg::PCM_W];
			out_chan_q <= chan_q;
			out_last_q <= cmd.nib;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < adx_pkg::NUM_CHANNELS; i++) begin
				frame_pos_q[i] <= '0;
				scale_q[i]     <= '0;
				h1_q[i]        <= '0;
				h2_q[i]        <= '0;
			end
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.fetch && chan_ok) begin
				frame_pos_q[chan_q] <= pos_next;
				if (restart_q) begin
					h1_q[chan_q] <= '0;
					h2_q[chan_q] <= '0;
				end
				if (pos == adx_pkg::POS_W'(0)) begin
					scale_q[chan_q][adx_pkg::SCALE_W-1:adx_pkg::BYTE_W] <= byte_q;
				end else if (pos == adx_pkg::POS_W'(1)) begin
					scale_q[chan_q][adx_pkg::BYTE_W-1:0] <= byte_q;
				end
			end
			if (cmd.sum) begin
				h2_q[chan_q] <= h1_q[chan_q];
				h1_q[chan_q] <= sample;
				out_valid_q  <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_chan_q;
	assign m_tlast  = out_last_q;

endmodule

// File: rtl/adx_adpcm_decoder_unit.sv
// ADX ADPCM decoder, one frame byte per accepted request.
// A scale byte passes through FETCH and back to IDLE before the next byte is taken.
// Data bytes make two passes of the shared predictor (multiply, then sum and clamp).
// Each pass registers one sample: the high nibble's first, then the low nibble's with m_tlast set.
// Asynchronous reset clears all per-channel frame positions, scales and histories.
// ----------------------------------------------------------------------------
// ADX ADPCM decoder unit
// Top level joining the sequencing controller and the decode datapath.
// ----------------------------------------------------------------------------
module adx_adpcm_decoder_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [adx_pkg::BYTE_W-1:0]    s_tdata,  // [7:0] frame_byte
	input  logic [adx_pkg::CHAN_W:0]      s_tuser,  // [0] chan, [1] restart
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [adx_pkg::PCM_W-1:0]     m_tdata,  // [15:0] pcm_sample
	output logic [adx_pkg::CHAN_W-1:0]    m_tuser,  // [0] out_chan
	output logic                          m_tlast
);

	adx_pkg::cmd_t    cmd;
	adx_pkg::status_t status;

	adx_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	adx_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.status     (status),
		.in_byte    (s_tdata),
		.in_chan    (s_tuser[adx_pkg::CHAN_W-1:0]),
		.in_restart (s_tuser[adx_pkg::CHAN_W]),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.m_tlast    (m_tlast)
	);

endmodule

// File: tb/adx_adpcm_decoder_unit_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ADX ADPCM decoder stream checker
// Watches both stream channels of the decoder, predicts the PCM samples that
// each accepted request causes, and compares every delivered sample with the
// oldest prediction still waiting.
// ----------------------------------------------------------------------------
module adx_adpcm_decoder_unit_chk (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	input  logic                          s_tready,
	input  logic [adx_pkg::BYTE_W-1:0]    s_tdata,  // [7:0] frame_byte
	input  logic [adx_pkg::CHAN_W:0]      s_tuser,  // [0] chan, [1] restart
	input  logic                          m_tvalid,
	input  logic                          m_tready,
	input  logic [adx_pkg::PCM_W-1:0]     m_tdata,  // [15:0] pcm_sample
	input  logic [adx_pkg::CHAN_W-1:0]    m_tuser,  // [0] out_chan
	input  logic                          m_tlast,
	output int                            mismatches,
	output int                            outstanding
);

	localparam int     FRAME_BYTES = 18;
	localparam longint STEP_GAIN   = 64'h4000;
	localparam longint TAP1        = 64'h7298;
	localparam longint TAP2        = 64'h3350;
	localparam longint PCM32_MAX   = 64'sh7fff_ffff;
	localparam longint PCM32_MIN   = -64'sh8000_0000;

	typedef struct packed {
		logic [15:0] pcm;
		logic        ch;
		logic        last;
	} sample_t;

	sample_t            pending_samples[$];
	logic [4:0]         frame_idx[2];
	logic [15:0]        scale_word[2];
	logic signed [31:0] hist1[2];
	logic signed [31:0] hist2[2];
	int                 bad_count;

	function automatic logic [15:0] decode_nibble(input logic ch, input logic [3:0] nib);
		longint code;
		longint scl;
		longint acc;
		code = longint'($signed(nib));
		scl  = longint'(scale_word[ch]) * 4;
		acc  = STEP_GAIN * code * scl
		     + ((TAP1 * longint'(hist1[ch])) >>> 14)
		     - ((TAP2 * longint'(hist2[ch])) >>> 14);
		if (acc > PCM32_MAX)
			acc = PCM32_MAX;
		else if (acc < PCM32_MIN)
			acc = PCM32_MIN;
		hist2[ch] = hist1[ch];
		hist1[ch] = acc[31:0];
		return acc[31:16];
	endfunction

	always @(posedge clk or negedge arst_n) begin
		logic       ch;
		logic [7:0] b;
		logic [4:0] p;
		sample_t    want;
		sample_t    got;
		if (!arst_n) begin
			pending_samples.delete();
			for (int i = 0; i < 2; i++) begin
				frame_idx[i]  = '0;
				scale_word[i] = '0;
				hist1[i]      = '0;
				hist2[i]      = '0;
			end
			bad_count = 0;
			mismatches  <= 0;
			outstanding <= 0;
		end else begin
			if (s_tvalid && s_tready) begin
				ch = s_tuser[0];
				b  = s_tdata;
				if (s_tuser[1]) begin
					hist1[ch]     = '0;
					hist2[ch]     = '0;
					frame_idx[ch] = '0;
				end
				p = frame_idx[ch];
				if (p >= FRAME_BYTES)
					p = '0;
				frame_idx[ch] = (p + 1 >= FRAME_BYTES) ? 5'd0 : p + 5'd1;
				if (p == 0) begin
					scale_word[ch][15:8] = b;
				end else if (p == 1) begin
					scale_word[ch][7:0] = b;
				end else begin
					want.ch   = ch;
					want.pcm  = decode_nibble(ch, b[7:4]);
					want.last = 1'b0;
					pending_samples.push_back(want);
					want.pcm  = decode_nibble(ch, b[3:0]);
					want.last = 1'b1;
					pending_samples.push_back(want);
				end
			end
			if (m_tvalid && m_tready) begin
				got.pcm  = m_tdata;
				got.ch   = m_tuser[0];
				got.last = m_tlast;
				if (pending_samples.size() == 0) begin
					bad_count++;
					if (bad_count <= 10)
						$display("ERROR: sample %h chan %0d last %0d arrived with none expected",
							got.pcm, got.ch, got.last);
				end else begin
					want = pending_samples.pop_front();
					if (got.pcm !== want.pcm || got.ch !== want.ch || got.last !== want.last) begin
						bad_count++;
						if (bad_count <= 10)
							$display("ERROR: expected pcm %h chan %0d last %0d, got pcm %h chan %0d last %0d",
								want.pcm, want.ch, want.last, got.pcm, got.ch, got.last);
					end
				end
			end
			mismatches  <= bad_count;
			outstanding <= pending_samples.size();
		end
	end

endmodule

// File: tb/adx_adpcm_decoder_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ADX ADPCM decoder unit testbench
// Feeds directed and random frame bytes on both channels, with restarts and
// random gaps and stalls, while the checker predicts and compares samples.
// ----------------------------------------------------------------------------
module adx_adpcm_decoder_unit_tb;

	localparam int CYCLE_LIMIT = 400000;
	localparam int RAND_ITEMS  = 650;
	localparam int CALM_FROM   = 560;

	logic                          clk;
	logic                          arst_n;
	logic                          s_tvalid;
	logic                          s_tready;
	logic [adx_pkg::BYTE_W-1:0]    s_tdata;
	logic [adx_pkg::CHAN_W:0]      s_tuser;
	logic                          m_tvalid;
	logic                          m_tready;
	logic [adx_pkg::PCM_W-1:0]     m_tdata;
	logic [adx_pkg::CHAN_W-1:0]    m_tuser;
	logic                          m_tlast;
	int                            mismatches;
	int                            outstanding;
	int                            cycles;
	bit                            calm;
	logic [4:0]                    frame_at[2];

	adx_adpcm_decoder_unit u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	adx_adpcm_decoder_unit_chk u_chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.m_tlast     (m_tlast),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("adx_adpcm_decoder_unit test failed");
			$finish;
		end
	end

	initial begin
		int hold;
		m_tready = 1'b0;
		hold = 0;
		forever begin
			@(posedge clk);
			if (hold > 0) begin
				m_tready <= 1'b0;
				hold--;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				m_tready <= 1'b0;
				hold = $urandom_range(1, 16) - 1;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Sends one request and returns at the edge where it is taken.
	task automatic send_byte(input logic ch, input logic [7:0] b, input logic rs);
		if (!calm && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tuser  <= {rs, ch};
		do @(posedge clk); while (!s_tready);
		if (rs)
			frame_at[ch] = '0;
		frame_at[ch] = (frame_at[ch] == 5'd17) ? 5'd0 : frame_at[ch] + 5'd1;
	endtask

	initial begin
		logic       ch;
		logic       rs;
		logic [7:0] b;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = '0;
		calm     = 1'b0;
		frame_at[0] = '0;
		frame_at[1] = '0;
		arst_n   = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Largest scale drives both clamps; both nibbles carry every sign extreme.
		send_byte(1'b0, 8'hFF, 1'b1);
		send_byte(1'b0, 8'hFF, 1'b0);
		send_byte(1'b0, 8'h7F, 1'b0);
		send_byte(1'b0, 8'h80, 1'b0);
		send_byte(1'b0, 8'h88, 1'b0);
		send_byte(1'b0, 8'h77, 1'b0);
		send_byte(1'b0, 8'h08, 1'b0);
		// Zero scale on the other channel leaves only the history terms.
		send_byte(1'b1, 8'h00, 1'b1);
		send_byte(1'b1, 8'h00, 1'b0);
		send_byte(1'b1, 8'h00, 1'b0);
		send_byte(1'b1, 8'hFF, 1'b0);
		// A restart in the middle of a frame starts a new one at once.
		send_byte(1'b0, 8'h12, 1'b1);
		send_byte(1'b0, 8'h34, 1'b0);
		send_byte(1'b0, 8'h9A, 1'b0);
		send_byte(1'b0, 8'h65, 1'b0);
		send_byte(1'b1, 8'h80, 1'b1);
		send_byte(1'b1, 8'h01, 1'b0);
		send_byte(1'b1, 8'hF1, 1'b0);
		send_byte(1'b1, 8'h1F, 1'b0);
		send_byte(1'b0, 8'hC3, 1'b0);
		send_byte(1'b1, 8'h3C, 1'b0);

		for (int n = 0; n < RAND_ITEMS; n++) begin
			calm = (n >= CALM_FROM);
			ch = $urandom_range(0, 1);
			rs = ($urandom_range(0, 39) == 0);
			b  = $urandom_range(0, 255);
			if (rs || frame_at[ch] == 5'd0) begin
				case ($urandom_range(0, 5))
					0:       b = 8'h00;
					1:       b = 8'hFF;
					2, 3:    b = $urandom_range(0, 3);
					default: b = $urandom_range(0, 255);
				endcase
			end
			send_byte(ch, b, rs);
		end

		s_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatches == 0) begin
			$display("adx_adpcm_decoder_unit test passed");
		end else begin
			$display("adx_adpcm_decoder_unit test failed");
		end
		$finish;
	end

endmodule

// File: filelist.f
rtl/adx_pkg.sv
rtl/adx_ctrl.sv
rtl/adx_datapath.sv
rtl/adx_adpcm_decoder_unit.sv
tb/adx_adpcm_decoder_unit_chk.sv
tb/adx_adpcm_decoder_unit_tb.sv
